[design/ccdc_pkg.sv]
// Shared constants and types for the center column defect check block.
// No dependencies; imported by every module of the block.
package ccdc_pkg;

    localparam int WINDOW_HALF = 10;
    localparam int SLOTS       = 2 * WINDOW_HALF + 1;
    localparam int SLOT_W      = 5;
    localparam int SAMPLE_BITS = 24;
    localparam int SUM_BITS    = SAMPLE_BITS + 13;
    localparam int CFG_W       = 13;
    localparam int COL_W       = 12;
    localparam int MAX_COLS    = 4096;
    localparam int MAX_ANGLES  = 4096;
    localparam int DIV_BITS    = SUM_BITS + 1;
    localparam int DCNT_W      = 6;
    localparam int CNT_W       = 5;

    localparam logic [2:0] ADDR_NUM_COLS   = 3'd0;
    localparam logic [2:0] ADDR_NUM_ANGLES = 3'd4;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_DIVST = 9'b000000010,
        S_DIVW  = 9'b000000100,
        S_MLOAD = 9'b000001000,
        S_MSCAN = 9'b000010000,
        S_MDEC  = 9'b000100000,
        S_FLAG  = 9'b001000000,
        S_OUT   = 9'b010000000,
        S_SPARE = 9'b100000000
    } t_state;

endpackage

[design/center_column_defect_check_unit.sv]
// Center column defect check, top level: window accumulator, report sequencer,
// output register. Depends on ccdc_pkg and ccdc_divider.
// Throughput: one sample per cycle while accumulating (read-add-write of one sum).
// Report after the last-marked sample: for each of the n = 2w+1 window columns the
// mean takes one pass of the shared divider, then the median search runs and the
// flag is registered, then one result per cycle as the sink allows.
// Reset (synchronous, active low): sums read as zero, registers to 2048/1024.
module center_column_defect_check_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // APB-style configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [2:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    // sample channel
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [ccdc_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic [ccdc_pkg::COL_W-1:0]         i_column,
    input  logic                               i_last_sample,
    // result channel
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [4:0]                  o_column_offset,
    output logic signed [ccdc_pkg::SAMPLE_BITS-1:0] o_column_mean,
    output logic [ccdc_pkg::SAMPLE_BITS-1:0]   o_spike_value,
    output logic [ccdc_pkg::SAMPLE_BITS-1:0]   o_median_spike,
    output logic                               o_defect_flag,
    output logic                               o_last_result
);
    import ccdc_pkg::*;

    // ---------------- configuration ----------------
    logic [CFG_W-1:0] r_num_cols, r_num_angles;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign prdata = (paddr == ADDR_NUM_ANGLES) ? {19'd0, r_num_angles}
                                               : {19'd0, r_num_cols};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_cols   <= CFG_W'(2048);
            r_num_angles <= CFG_W'(1024);
        end else if (cfg_wr) begin
            unique case (paddr)
                ADDR_NUM_COLS:   r_num_cols   <= pwdata[CFG_W-1:0];
                ADDR_NUM_ANGLES: r_num_angles <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // effective geometry: clamp columns to 4..MAX_COLS, angles to 1..MAX_ANGLES
    logic [CFG_W-1:0]  eff_cols, eff_ang;
    logic [CFG_W-1:0]  center;
    logic [3:0]        w;
    logic [SLOT_W-1:0] last_idx;   // n - 1 = 2w

    always_comb begin
        eff_cols = r_num_cols;
        if (r_num_cols < CFG_W'(4))        eff_cols = CFG_W'(4);
        if (r_num_cols > CFG_W'(MAX_COLS)) eff_cols = CFG_W'(MAX_COLS);
        eff_ang = r_num_angles;
        if (r_num_angles == '0)               eff_ang = CFG_W'(1);
        if (r_num_angles > CFG_W'(MAX_ANGLES)) eff_ang = CFG_W'(MAX_ANGLES);
        center = eff_cols >> 1;
        if (center - 1'b1 > CFG_W'(WINDOW_HALF)) w = 4'(WINDOW_HALF);
        else                                     w = 4'(center - 1'b1);
        last_idx = {w, 1'b0};
    end

    // ---------------- sequencer state ----------------
    t_state r_state;
    logic [SLOT_W-1:0] r_idx;

    // ---------------- window sums ----------------
    logic signed [SUM_BITS-1:0] r_sums [SLOTS];
    logic [SLOTS-1:0]           r_sum_vld;   // clear bit means the sum reads zero
    logic                       in_acc, in_win;
    logic [CFG_W-1:0]           col_w;
    logic [SLOT_W-1:0]          slot, rd_slot;
    logic signed [SUM_BITS-1:0] sum_rd;
    logic signed [SUM_BITS:0]   sum_add;
    logic signed [SUM_BITS-1:0] sum_new;
    logic                       clr_sums;

    assign o_stall = (r_state != S_IDLE);
    assign in_acc  = i_valid & (r_state == S_IDLE);
    assign col_w   = {1'b0, i_column} + {9'd0, w};
    assign in_win  = (col_w >= center) && ({1'b0, i_column} <= center + {9'd0, w});
    assign slot    = SLOT_W'(col_w - center);
    assign rd_slot = (r_state == S_IDLE) ? slot : r_idx;
    assign sum_rd  = r_sum_vld[rd_slot] ? r_sums[rd_slot] : '0;

    always_comb begin
        sum_add = SUM_BITS'(0) + {sum_rd[SUM_BITS-1], sum_rd}
                  + (SUM_BITS+1)'(i_sample);
        // saturate to the signed sum range
        if (sum_add[SUM_BITS] != sum_add[SUM_BITS-1])
            sum_new = sum_add[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                        : {1'b0, {(SUM_BITS-1){1'b1}}};
        else
            sum_new = sum_add[SUM_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_vld <= '0;
        end else if (clr_sums) begin
            r_sum_vld <= '0;
        end else if (in_acc && in_win) begin
            r_sum_vld[slot] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && in_win) begin
            r_sums[slot] <= sum_new;
        end
    end

    // ---------------- shared divider: mean = round(|sum| / angles) ----------------
    logic                  div_start, div_done;
    logic [DIV_BITS-1:0]   div_dvd, div_q;
    logic [SUM_BITS-1:0]   sum_mag;
    logic                  r_neg;

    assign sum_mag   = sum_rd[SUM_BITS-1] ? SUM_BITS'(-sum_rd) : SUM_BITS'(sum_rd);
    assign div_start = (r_state == S_DIVST);
    assign div_dvd   = {1'b0, sum_mag} + DIV_BITS'(eff_ang >> 1);

    ccdc_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (eff_ang),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    // saturated signed mean from the quotient
    logic signed [SAMPLE_BITS-1:0] mean_new;
    always_comb begin
        if (r_neg) begin
            if (div_q >= DIV_BITS'(1 << (SAMPLE_BITS - 1)))
                mean_new = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            else
                mean_new = SAMPLE_BITS'(-div_q[SAMPLE_BITS-1:0]);
        end else begin
            if (div_q > DIV_BITS'((1 << (SAMPLE_BITS - 1)) - 1))
                mean_new = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            else
                mean_new = div_q[SAMPLE_BITS-1:0];
        end
    end

    // spike of the previous column from a sliding pair of earlier means
    logic signed [SAMPLE_BITS-1:0] r_m0, r_m1;
    logic signed [SAMPLE_BITS+2:0] df;
    logic [SAMPLE_BITS+2:0]        df_mag;
    logic [SAMPLE_BITS+1:0]        sp_half;
    logic [SAMPLE_BITS-1:0]        sp_new;

    always_comb begin
        df      = ((SAMPLE_BITS+3)'(r_m1) <<< 1) - (SAMPLE_BITS+3)'(r_m0)
                  - (SAMPLE_BITS+3)'(mean_new);
        df_mag  = df[SAMPLE_BITS+2] ? (SAMPLE_BITS+3)'(-df) : df;
        sp_half = (SAMPLE_BITS+2)'((df_mag + 1'b1) >> 1);
        sp_new  = (sp_half[SAMPLE_BITS+1:SAMPLE_BITS] != 2'b00)
                  ? {SAMPLE_BITS{1'b1}} : sp_half[SAMPLE_BITS-1:0];
    end

    logic signed [SAMPLE_BITS-1:0] r_means  [SLOTS];
    logic [SAMPLE_BITS-1:0]        r_spikes [SLOTS];
    logic [SAMPLE_BITS-1:0]        r_csp;      // center spike

    // ---------------- median search ----------------
    // Candidate k is the upper median when (#less <= m) and (#less-or-equal > m),
    // m = (2w-2)/2 = w-1.
    logic [SLOT_W-1:0]      r_k, r_j;
    logic [SAMPLE_BITS-1:0] r_cand, r_median;
    logic [CNT_W-1:0]       r_lt, r_le;
    logic [CNT_W-1:0]       med_pos;
    logic [SLOT_W-1:0]      k_next;
    logic [SAMPLE_BITS+1:0] three_med;
    logic                   r_defect;

    assign med_pos   = CNT_W'(w) - 1'b1;
    assign k_next    = (r_k + 1'b1 == SLOT_W'(w)) ? r_k + SLOT_W'(2) : r_k + 1'b1;
    assign three_med = ({2'b00, r_median} << 1) + {2'b00, r_median};

    // ---------------- output register ----------------
    logic out_load;
    logic r_ovalid;
    assign out_load = (r_state == S_OUT) && (!r_ovalid || !i_stall);
    assign clr_sums = out_load && (r_idx == last_idx);

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && i_last_sample) begin
                        r_state <= S_DIVST;
                        r_idx   <= '0;
                    end
                end
                S_DIVST: r_state <= S_DIVW;
                S_DIVW: begin
                    if (div_done) begin
                        if (r_idx == last_idx) begin
                            r_state <= S_MLOAD;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_DIVST;
                        end
                    end
                end
                S_MLOAD: begin
                    if (w == 4'd1) r_state <= S_FLAG;   // no non-center inner spikes
                    else           r_state <= S_MSCAN;
                end
                S_MSCAN: begin
                    if (r_j == last_idx - 1'b1) r_state <= S_MDEC;
                end
                S_MDEC: begin
                    if (r_lt <= med_pos && r_le > med_pos) r_state <= S_FLAG;
                    else                                   r_state <= S_MLOAD;
                end
                S_FLAG: begin
                    r_state <= S_OUT;
                    r_idx   <= '0;
                end
                S_OUT: begin
                    if (out_load) begin
                        if (r_idx == last_idx) r_state <= S_IDLE;
                        else                   r_idx   <= r_idx + 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers of the report
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_k <= SLOT_W'(1);
            end
            S_DIVST: begin
                r_neg <= sum_rd[SUM_BITS-1];
            end
            S_DIVW: begin
                if (div_done) begin
                    r_means[r_idx] <= mean_new;
                    r_m0 <= r_m1;
                    r_m1 <= mean_new;
                    if (r_idx >= SLOT_W'(2)) begin
                        r_spikes[r_idx - 1'b1] <= sp_new;
                        if (r_idx - 1'b1 == SLOT_W'(w)) r_csp <= sp_new;
                    end
                end
            end
            S_MLOAD: begin
                r_cand   <= r_spikes[r_k];
                r_j      <= SLOT_W'(1);
                r_lt     <= '0;
                r_le     <= '0;
                r_median <= '0;
            end
            S_MSCAN: begin
                if (r_j != SLOT_W'(w)) begin
                    if (r_spikes[r_j] < r_cand)  r_lt <= r_lt + 1'b1;
                    if (r_spikes[r_j] <= r_cand) r_le <= r_le + 1'b1;
                end
                r_j <= r_j + 1'b1;
            end
            S_MDEC: begin
                if (r_lt <= med_pos && r_le > med_pos) r_median <= r_cand;
                else                                   r_k      <= k_next;
            end
            S_FLAG: begin
                r_defect <= (r_median != '0) && ({2'b00, r_csp} > three_med);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_column_offset <= 5'(r_idx - SLOT_W'(w));
            o_column_mean   <= r_means[r_idx];
            o_spike_value   <= (r_idx == '0 || r_idx == last_idx) ? '0 : r_spikes[r_idx];
            o_median_spike  <= r_median;
            o_defect_flag   <= r_defect;
            o_last_result   <= (r_idx == last_idx);
        end
    end

    assign o_valid = r_ovalid;
endmodule

[design/ccdc_divider.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on ccdc_pkg.
module ccdc_divider (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ccdc_pkg::DIV_BITS-1:0] i_dividend,
    input  logic [ccdc_pkg::CFG_W-1:0]    i_divisor,
    output logic                          o_done,
    output logic [ccdc_pkg::DIV_BITS-1:0] o_quot
);
    import ccdc_pkg::*;

    logic [CFG_W-1:0]    r_rem, n_rem;
    logic [CFG_W-1:0]    r_div;
    logic [DIV_BITS-1:0] r_q;
    logic [DCNT_W-1:0]   r_cnt;
    logic                r_busy, r_done;
    logic [CFG_W:0]      trial;
    logic                qbit;

    always_comb begin
        trial = {r_rem, r_q[DIV_BITS-1]};
        qbit  = (trial >= {1'b0, r_div});
        n_rem = qbit ? CFG_W'(trial - {1'b0, r_div}) : CFG_W'(trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DCNT_W'(DIV_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DIV_BITS-2:0], qbit};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

[verif/tb.sv]
// Testbench for center_column_defect_check_unit: random and directed sinograms,
// in-bench predictor of the window means, spikes, median and defect decision.
// Depends on ccdc_pkg and the RTL of the block.
module tb;
    import ccdc_pkg::*;

    // one expected report row
    typedef struct {
        logic signed [4:0]             offset;
        logic signed [SAMPLE_BITS-1:0] mean;
        logic [SAMPLE_BITS-1:0]        spike;
        logic [SAMPLE_BITS-1:0]        median;
        logic                          defect;
        logic                          last;
    } t_report_row;

    // Scoreboard: holds its own copy of the column sums and the registers,
    // predicts a full report on each last-marked transaction.
    class defect_scoreboard;
        logic [CFG_W-1:0] cols_reg;
        logic [CFG_W-1:0] angles_reg;
        longint sums[SLOTS];
        t_report_row pending[$];
        int errors;

        function void clear();
            cols_reg = 13'd2048;
            angles_reg = 13'd1024;
            foreach (sums[k]) sums[k] = 0;
            pending.delete();
            errors = 0;
        endfunction

        function longint rounded_mean(longint s, longint d);
            longint mag;
            longint q;
            mag = (s < 0) ? -s : s;
            q = (mag + d / 2) / d;
            if (s < 0) begin
                if (q > (longint'(1) << (SAMPLE_BITS - 1))) q = longint'(1) << (SAMPLE_BITS - 1);
                return -q;
            end
            if (q > (longint'(1) << (SAMPLE_BITS - 1)) - 1) q = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
            return q;
        endfunction

        function void note_sample(logic signed [SAMPLE_BITS-1:0] smp,
                                  logic [COL_W-1:0] col, logic last);
            longint ncols, center, half, width, d, s, lim;
            longint means[SLOTS];
            longint spikes[SLOTS];
            longint others[$];
            longint mag, sp, median;
            logic defect;
            t_report_row row;
            ncols = cols_reg;
            if (ncols < 4) ncols = 4;
            if (ncols > MAX_COLS) ncols = MAX_COLS;
            center = ncols / 2;
            half = center - 1;
            if (half > WINDOW_HALF) half = WINDOW_HALF;
            width = 2 * half + 1;
            lim = (longint'(1) << (SUM_BITS - 1)) - 1;
            if (longint'(col) + half >= center && longint'(col) <= center + half) begin
                s = sums[col + half - center] + longint'(smp);
                if (s > lim) s = lim;
                if (s < -lim - 1) s = -lim - 1;
                sums[col + half - center] = s;
            end
            if (!last) return;
            d = angles_reg;
            if (d < 1) d = 1;
            if (d > MAX_ANGLES) d = MAX_ANGLES;
            for (int k = 0; k < width; k++) means[k] = rounded_mean(sums[k], d);
            for (int k = 0; k < width; k++) begin
                spikes[k] = 0;
                if (k > 0 && k + 1 < width) begin
                    mag = 2 * means[k] - means[k-1] - means[k+1];
                    if (mag < 0) mag = -mag;
                    sp = (mag + 1) >> 1;
                    if (sp > (longint'(1) << SAMPLE_BITS) - 1) sp = (longint'(1) << SAMPLE_BITS) - 1;
                    spikes[k] = sp;
                    if (k != half) others = {others, sp};
                end
            end
            others.sort();
            median = (others.size() > 0) ? others[others.size() / 2] : 0;
            defect = (median > 0) && (spikes[half] > 3 * median);
            for (int k = 0; k < width; k++) begin
                row.offset = 5'(k - half);
                row.mean = SAMPLE_BITS'(means[k]);
                row.spike = SAMPLE_BITS'(spikes[k]);
                row.median = SAMPLE_BITS'(median);
                row.defect = defect;
                row.last = (k + 1 == width);
                pending = {pending, row};
            end
            foreach (sums[k]) sums[k] = 0;
        endfunction

        function void check_row(t_report_row got);
            t_report_row exp_row;
            if (pending.size() == 0) begin
                $error("unexpected result transaction, offset %0d", got.offset);
                errors++;
                return;
            end
            exp_row = pending.pop_front();
            if (got.offset !== exp_row.offset) begin
                $error("column_offset exp %0d got %0d", exp_row.offset, got.offset); errors++;
            end
            if (got.mean !== exp_row.mean) begin
                $error("column_mean exp %0d got %0d", exp_row.mean, got.mean); errors++;
            end
            if (got.spike !== exp_row.spike) begin
                $error("spike_value exp %0d got %0d", exp_row.spike, got.spike); errors++;
            end
            if (got.median !== exp_row.median) begin
                $error("median_spike exp %0d got %0d", exp_row.median, got.median); errors++;
            end
            if (got.defect !== exp_row.defect) begin
                $error("defect_flag exp %0d got %0d", exp_row.defect, got.defect); errors++;
            end
            if (got.last !== exp_row.last) begin
                $error("last_result exp %0d got %0d", exp_row.last, got.last); errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic i_valid = 1'b0;
    logic o_stall;
    logic signed [SAMPLE_BITS-1:0] i_sample = '0;
    logic [COL_W-1:0] i_column = '0;
    logic i_last_sample = 1'b0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic signed [4:0] o_column_offset;
    logic signed [SAMPLE_BITS-1:0] o_column_mean;
    logic [SAMPLE_BITS-1:0] o_spike_value, o_median_spike;
    logic o_defect_flag, o_last_result;

    center_column_defect_check_unit dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    defect_scoreboard board = new();

    // idle percentages for the two sides; hold_on forces a long sink stall
    int send_idle_pct = 0;
    int sink_idle_pct = 0;
    logic hold_on = 1'b0;
    longint cycle_count = 0;
    int sent = 0;
    int mode = 0;

    // Result side: accept and check on every edge with valid high, stall low.
    // Stall for the next cycle is drawn here, one assignment per edge.
    always @(posedge i_clk) begin
        t_report_row got;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_valid && !i_stall) begin
            got.offset = o_column_offset;
            got.mean = o_column_mean;
            got.spike = o_spike_value;
            got.median = o_median_spike;
            got.defect = o_defect_flag;
            got.last = o_last_result;
            board.check_row(got);
        end
        if (hold_on) begin
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < sink_idle_pct);
        end
    end

    // long sink hold-off in the last phase, counted here while samples keep coming
    initial begin
        wait (mode == 2);
        @(posedge i_clk);
        hold_on <= 1'b1;
        repeat (3000) @(posedge i_clk);
        hold_on <= 1'b0;
    end

    // generous limit: the median search and the divider dominate each report
    always @(posedge i_clk) begin
        if (cycle_count > 1500000) begin
            $display("FAILURE");
            $finish;
        end
    end

    // APB write: setup then access cycle, pready is tied high
    task automatic write_reg(input logic [2:0] addr, input logic [12:0] value);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == ADDR_NUM_COLS) board.cols_reg = value;
        else board.angles_reg = value;
    endtask

    // offer one sample transaction, holding it until accepted
    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] smp,
                               input logic [COL_W-1:0] col, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_sample <= smp;
        i_column <= col;
        i_last_sample <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.note_sample(smp, col, last);
        sent++;
    endtask

    task automatic go_idle();
        i_valid <= 1'b0;
    endtask

    // drain: wait for all rows, then some slack before the next register write
    task automatic drain();
        go_idle();
        while (board.pending.size() > 0) @(posedge i_clk);
        repeat (2000) @(posedge i_clk);
    endtask

    function automatic logic [COL_W-1:0] window_column(int ncols);
        int c, h;
        c = ncols / 2;
        h = (c - 1 > WINDOW_HALF) ? WINDOW_HALF : c - 1;
        if ($urandom_range(9) == 0) return COL_W'($urandom);
        return COL_W'(c - h + $urandom_range(2 * h));
    endfunction

    // one sinogram: rows of window columns with random values, last mark at end
    task automatic send_frame(input int ncols, input int rows, input int kind);
        logic signed [SAMPLE_BITS-1:0] v;
        int c, h;
        c = (ncols < 4) ? 2 : ((ncols > MAX_COLS) ? MAX_COLS / 2 : ncols / 2);
        h = (c - 1 > WINDOW_HALF) ? WINDOW_HALF : c - 1;
        for (int r = 0; r < rows; r++) begin
            for (int k = -h; k <= h; k++) begin
                case (kind)
                    0: v = SAMPLE_BITS'($urandom);
                    1: v = SAMPLE_BITS'($signed($urandom_range(2000)) - 1000
                           + ((k == 0) ? 300000 : 0));
                    default: v = SAMPLE_BITS'($urandom_range(64) * k * k);
                endcase
                send_sample(v, COL_W'(c + k), (r == rows - 1) && (k == h));
            end
        end
    endtask

    initial begin
        board.clear();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: smallest window, extremes, outside columns, lone last mark
        write_reg(ADDR_NUM_COLS, 13'd4);
        write_reg(ADDR_NUM_ANGLES, 13'd1);
        send_sample(24'sh7fffff, 12'd1, 1'b0);
        send_sample(24'sh800000, 12'd2, 1'b0);
        send_sample(24'sh800000, 12'd2, 1'b0);
        send_sample(24'sh000001, 12'd3, 1'b0);
        send_sample(24'sh123456, 12'hfff, 1'b0);
        send_sample(24'sh000000, 12'd0, 1'b1);
        drain();
        write_reg(ADDR_NUM_COLS, 13'd0);
        write_reg(ADDR_NUM_ANGLES, 13'd0);
        send_sample(24'sh7fffff, 12'd2, 1'b1);
        send_sample(24'sh000000, 12'hfff, 1'b1);
        drain();
        write_reg(ADDR_NUM_COLS, 13'h1fff);
        write_reg(ADDR_NUM_ANGLES, 13'h1fff);
        send_frame(8191, 1, 0);
        drain();
        write_reg(ADDR_NUM_COLS, 13'd4096);
        write_reg(ADDR_NUM_ANGLES, 13'd2);
        send_frame(4096, 1, 1);
        drain();
        write_reg(ADDR_NUM_COLS, 13'd6);
        write_reg(ADDR_NUM_ANGLES, 13'd4096);
        send_frame(6, 2, 2);
        drain();

        // random phases: sender sparse idles, then receiver sparse, then none
        for (mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 8 : ((mode == 1) ? 87 : 0);
            sink_idle_pct = (mode == 0) ? 87 : ((mode == 1) ? 8 : 0);
            while (sent < 110 + 80 * mode) begin
                int nc, rows;
                nc = ($urandom_range(3) == 0) ? $urandom_range(4, 12)
                                              : $urandom_range(22, 4096);
                rows = $urandom_range(1, 3);
                write_reg(ADDR_NUM_COLS, 13'(nc));
                write_reg(ADDR_NUM_ANGLES, 13'($urandom_range(1, rows + 2)));
                send_frame(nc, rows, $urandom_range(2));
                // occasional noise sample outside or inside the window
                if ($urandom_range(3) == 0)
                    send_sample(SAMPLE_BITS'($urandom), window_column(nc), 1'b0);
                drain();
            end
        end

        drain();
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
